[rtl/core/sfp_pkg.sv]
package sfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hA3;
  localparam logic [7:0] TYPE_POS    = 8'hB3;
  localparam logic [7:0] TYPE_DIR    = 8'hB4;
  localparam logic [7:0] TYPE_CIRCLE = 8'hB5;
  localparam logic [7:0] END_BYTE    = 8'hFF;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_TYPE    = 2'd1,
    ST_COLLECT = 2'd2
  } parse_state_t;

  typedef enum logic [2:0] {
    KIND_NONE      = 3'd0,
    KIND_ANGLE     = 3'd1,
    KIND_POSITION  = 3'd2,
    KIND_DIRECTION = 3'd3,
    KIND_CIRCLE    = 3'd4,
    KIND_INVALID   = 3'd5
  } packet_kind_t;

  typedef struct packed {
    packet_kind_t       kind;
    logic               header_error;
    logic               overflow;
    logic signed [15:0] position_x;
    logic [7:0]         direction;
    logic signed [15:0] ring_x;
    logic signed [15:0] ring_y;
    logic [31:0]        bytes_seen;
    logic [31:0]        good_packets;
    logic [31:0]        bad_packets;
  } result_t;

endpackage

[rtl/core/sfp_parser.sv]
module sfp_parser #(
  parameter int FRAME_DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             opcode,
  input  logic [7:0]       rx_byte,
  output sfp_pkg::result_t res
);

  localparam int FILL_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W  = $clog2(FRAME_DEPTH);

  sfp_pkg::parse_state_t state, state_next;
  logic [7:0]         packet_type, packet_type_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [7:0]         frame_store [FRAME_DEPTH];
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic signed [15:0] position, position_next;
  logic [7:0]         direction, direction_next;
  logic signed [15:0] ring_x, ring_x_next;
  logic signed [15:0] ring_y, ring_y_next;
  logic [31:0]        byte_cnt, byte_cnt_next;
  logic [31:0]        good_cnt, good_cnt_next;
  logic [31:0]        bad_cnt, bad_cnt_next;
  logic [FILL_W-1:0]  fill_inc;
  logic [1:0]         bad_inc;
  logic               good_inc;
  sfp_pkg::packet_kind_t kind;
  logic               hdr_err;
  logic               ovf;

  assign fill_inc = fill + FILL_W'(1);

  always_comb begin
    state_next       = state;
    packet_type_next = packet_type;
    fill_next        = fill;
    wr_en            = 1'b0;
    wr_idx           = fill[IDX_W-1:0];
    position_next    = position;
    direction_next   = direction;
    ring_x_next      = ring_x;
    ring_y_next      = ring_y;
    byte_cnt_next    = byte_cnt;
    bad_inc          = 2'd0;
    good_inc         = 1'b0;
    kind             = sfp_pkg::KIND_NONE;
    hdr_err          = 1'b0;
    ovf              = 1'b0;
    if (step) begin
      if (opcode == sfp_pkg::OP_RESTART) begin
        state_next = sfp_pkg::ST_HUNT;
        fill_next  = '0;
      end else begin
        byte_cnt_next = byte_cnt + 32'd1;
        unique case (state)
          sfp_pkg::ST_TYPE: begin
            if (rx_byte == sfp_pkg::TYPE_POS || rx_byte == sfp_pkg::TYPE_DIR ||
                rx_byte == sfp_pkg::TYPE_CIRCLE) begin
              packet_type_next = rx_byte;
              wr_en            = (fill < FILL_W'(FRAME_DEPTH));
              fill_next        = fill_inc;
              state_next       = sfp_pkg::ST_COLLECT;
            end else if (rx_byte == sfp_pkg::HDR_BYTE) begin
              wr_en     = 1'b1;
              wr_idx    = '0;
              fill_next = FILL_W'(1);
            end else begin
              state_next = sfp_pkg::ST_HUNT;
              bad_inc    = 2'd1;
              hdr_err    = 1'b1;
            end
          end
          sfp_pkg::ST_COLLECT: begin
            wr_en     = (fill < FILL_W'(FRAME_DEPTH));
            fill_next = fill_inc;
            if (rx_byte == sfp_pkg::END_BYTE) begin
              state_next = sfp_pkg::ST_HUNT;
              // decode never reads the terminator itself, only earlier entries
              if (packet_type == sfp_pkg::TYPE_POS && fill_inc >= FILL_W'(5)) begin
                good_inc = 1'b1;
                if (fill_inc >= FILL_W'(7)) begin
                  position_next = {frame_store[4], frame_store[5]};
                  kind          = sfp_pkg::KIND_POSITION;
                end else begin
                  kind = sfp_pkg::KIND_ANGLE;
                end
              end else if (packet_type == sfp_pkg::TYPE_DIR &&
                           fill_inc >= FILL_W'(4)) begin
                good_inc       = 1'b1;
                direction_next = frame_store[2];
                kind           = sfp_pkg::KIND_DIRECTION;
              end else if (packet_type == sfp_pkg::TYPE_CIRCLE &&
                           fill_inc >= FILL_W'(7)) begin
                good_inc    = 1'b1;
                ring_x_next = {frame_store[2], frame_store[3]};
                ring_y_next = {frame_store[4], frame_store[5]};
                kind        = sfp_pkg::KIND_CIRCLE;
              end else begin
                bad_inc = 2'd1;
                kind    = sfp_pkg::KIND_INVALID;
              end
            end
            // full buffer counts on top of any decode on this word
            if (fill_inc >= FILL_W'(FRAME_DEPTH)) begin
              state_next = sfp_pkg::ST_HUNT;
              bad_inc    = bad_inc + 2'd1;
              ovf        = 1'b1;
            end
          end
          default: begin
            if (rx_byte == sfp_pkg::HDR_BYTE) begin
              wr_en      = 1'b1;
              wr_idx     = '0;
              fill_next  = FILL_W'(1);
              state_next = sfp_pkg::ST_TYPE;
            end
          end
        endcase
      end
    end
    good_cnt_next = good_cnt + 32'(good_inc);
    bad_cnt_next  = bad_cnt + 32'(bad_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sfp_pkg::ST_HUNT;
      packet_type <= '0;
      fill        <= '0;
      position    <= '0;
      direction   <= '0;
      ring_x      <= '0;
      ring_y      <= '0;
      byte_cnt    <= '0;
      good_cnt    <= '0;
      bad_cnt     <= '0;
    end else begin
      state       <= state_next;
      packet_type <= packet_type_next;
      fill        <= fill_next;
      position    <= position_next;
      direction   <= direction_next;
      ring_x      <= ring_x_next;
      ring_y      <= ring_y_next;
      byte_cnt    <= byte_cnt_next;
      good_cnt    <= good_cnt_next;
      bad_cnt     <= bad_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_idx] <= rx_byte;
    end
  end

  always_comb begin
    res.kind         = kind;
    res.header_error = hdr_err;
    res.overflow     = ovf;
    res.position_x   = position_next;
    res.direction    = direction_next;
    res.ring_x       = ring_x_next;
    res.ring_y       = ring_y_next;
    res.bytes_seen   = byte_cnt_next;
    res.good_packets = good_cnt_next;
    res.bad_packets  = bad_cnt_next;
  end

endmodule

[rtl/core/sensor_frame_parser_core.sv]
// path: an accepted word passes the input register and the parser into the output register
// throughput: one word per cycle; the parser state updates in the cycle a word
// leaves the input register, so the next word sees it at once; a stalled output
// holds both registers and stalls the input once the input register is full
// reset: synchronous, active high; parser hunts for a header, counters and held
// values are zero, the frame buffer holds no defined data
module sensor_frame_parser_core #(
  parameter int FRAME_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         packet_kind,
  output logic               header_error,
  output logic               overflow,
  output logic signed [15:0] position_x,
  output logic [7:0]         direction,
  output logic signed [15:0] ring_x,
  output logic signed [15:0] ring_y,
  output logic [31:0]        bytes_seen,
  output logic [31:0]        good_packets,
  output logic [31:0]        bad_packets
);

  logic             s1_valid;
  logic             s1_opcode;
  logic [7:0]       s1_byte;
  logic             advance;
  logic             in_take;
  sfp_pkg::result_t res_comb;
  sfp_pkg::result_t res;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  sfp_parser #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .opcode  (s1_opcode),
    .rx_byte (s1_byte),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode <= opcode;
      s1_byte   <= rx_byte;
    end
    if (advance) begin
      res <= res_comb;
    end
  end

  assign packet_kind  = res.kind;
  assign header_error = res.header_error;
  assign overflow     = res.overflow;
  assign position_x   = res.position_x;
  assign direction    = res.direction;
  assign ring_x       = res.ring_x;
  assign ring_y       = res.ring_y;
  assign bytes_seen   = res.bytes_seen;
  assign good_packets = res.good_packets;
  assign bad_packets  = res.bad_packets;

endmodule

[sim/sensor_frame_parser_core_tb.sv]
module sensor_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_DEPTH = 8;
  localparam int CYCLE_LIMIT = 120000;
  localparam int LONG_HOLD = 80;

  // mirror of the parser: tracks its state and queues the report each word should produce
  class deframer_mirror;
    sfp_pkg::parse_state_t st;
    logic [7:0]   pkt_type;
    logic [7:0]   frame [FRAME_DEPTH];
    int           fill;
    logic [15:0]  pos;
    logic [7:0]   dir;
    logic [15:0]  rx;
    logic [15:0]  ry;
    logic [31:0]  byte_cnt;
    logic [31:0]  good_cnt;
    logic [31:0]  bad_cnt;
    sfp_pkg::result_t awaited [$];
    int           mismatches;

    function new();
      st = sfp_pkg::ST_HUNT;
      pkt_type = '0;
      fill = 0;
      pos = '0;
      dir = '0;
      rx = '0;
      ry = '0;
      byte_cnt = '0;
      good_cnt = '0;
      bad_cnt = '0;
      mismatches = 0;
    endfunction

    function void stash(logic [7:0] b);
      if (fill < FRAME_DEPTH) frame[fill] = b;
      fill++;
    endfunction

    function void absorb_word(logic op, logic [7:0] b);
      sfp_pkg::result_t r;
      r = '0;
      r.kind = sfp_pkg::KIND_NONE;
      if (op == sfp_pkg::OP_RESTART) begin
        st = sfp_pkg::ST_HUNT;
        fill = 0;
      end else begin
        byte_cnt++;
        case (st)
          sfp_pkg::ST_TYPE: begin
            if (b == sfp_pkg::TYPE_POS || b == sfp_pkg::TYPE_DIR ||
                b == sfp_pkg::TYPE_CIRCLE) begin
              pkt_type = b;
              stash(b);
              st = sfp_pkg::ST_COLLECT;
            end else if (b == sfp_pkg::HDR_BYTE) begin
              // repeated header starts the packet over
              fill = 0;
              stash(b);
            end else begin
              st = sfp_pkg::ST_HUNT;
              bad_cnt++;
              r.header_error = 1'b1;
            end
          end
          sfp_pkg::ST_COLLECT: begin
            stash(b);
            if (b == sfp_pkg::END_BYTE) begin
              st = sfp_pkg::ST_HUNT;
              if (pkt_type == sfp_pkg::TYPE_POS && fill >= 5) begin
                good_cnt++;
                if (fill >= 7) begin
                  pos = {frame[4], frame[5]};
                  r.kind = sfp_pkg::KIND_POSITION;
                end else begin
                  r.kind = sfp_pkg::KIND_ANGLE;
                end
              end else if (pkt_type == sfp_pkg::TYPE_DIR && fill >= 4) begin
                dir = frame[2];
                good_cnt++;
                r.kind = sfp_pkg::KIND_DIRECTION;
              end else if (pkt_type == sfp_pkg::TYPE_CIRCLE && fill >= 7) begin
                rx = {frame[2], frame[3]};
                ry = {frame[4], frame[5]};
                good_cnt++;
                r.kind = sfp_pkg::KIND_CIRCLE;
              end else begin
                bad_cnt++;
                r.kind = sfp_pkg::KIND_INVALID;
              end
            end
            // full buffer counts even when the same word closed the packet
            if (fill >= FRAME_DEPTH) begin
              st = sfp_pkg::ST_HUNT;
              bad_cnt++;
              r.overflow = 1'b1;
            end
          end
          default: begin
            if (b == sfp_pkg::HDR_BYTE) begin
              fill = 0;
              stash(b);
              st = sfp_pkg::ST_TYPE;
            end
          end
        endcase
      end
      r.position_x = pos;
      r.direction = dir;
      r.ring_x = rx;
      r.ring_y = ry;
      r.bytes_seen = byte_cnt;
      r.good_packets = good_cnt;
      r.bad_packets = bad_cnt;
      awaited.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        mismatches++;
      end
    endfunction

    function void compare_result(sfp_pkg::result_t got);
      sfp_pkg::result_t e;
      if (awaited.size() == 0) begin
        $error("report arrived with no word pending");
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      field_check("packet_kind", 32'(e.kind), 32'(got.kind));
      field_check("header_error", 32'(e.header_error), 32'(got.header_error));
      field_check("overflow", 32'(e.overflow), 32'(got.overflow));
      field_check("position_x", 32'(e.position_x), 32'(got.position_x));
      field_check("direction", 32'(e.direction), 32'(got.direction));
      field_check("ring_x", 32'(e.ring_x), 32'(got.ring_x));
      field_check("ring_y", 32'(e.ring_y), 32'(got.ring_y));
      field_check("bytes_seen", e.bytes_seen, got.bytes_seen);
      field_check("good_packets", e.good_packets, got.good_packets);
      field_check("bad_packets", e.bad_packets, got.bad_packets);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = sfp_pkg::OP_BYTE;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         packet_kind;
  logic               header_error;
  logic               overflow;
  logic signed [15:0] position_x;
  logic [7:0]         direction;
  logic signed [15:0] ring_x;
  logic signed [15:0] ring_y;
  logic [31:0]        bytes_seen;
  logic [31:0]        good_packets;
  logic [31:0]        bad_packets;

  deframer_mirror   tracker = new();
  sfp_pkg::result_t got;
  logic [7:0]       frame_bytes [$];
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_cycles = 0;
  int               words_sent = 0;
  int               results_seen = 0;
  int               cycle_count = 0;

  sensor_frame_parser_core #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .packet_kind(packet_kind),
    .header_error(header_error),
    .overflow(overflow),
    .position_x(position_x),
    .direction(direction),
    .ring_x(ring_x),
    .ring_y(ring_y),
    .bytes_seen(bytes_seen),
    .good_packets(good_packets),
    .bad_packets(bad_packets)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output side: check each accepted report, then choose the next stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.kind = sfp_pkg::packet_kind_t'(packet_kind);
        got.header_error = header_error;
        got.overflow = overflow;
        got.position_x = position_x;
        got.direction = direction;
        got.ring_x = ring_x;
        got.ring_y = ring_y;
        got.bytes_seen = bytes_seen;
        got.good_packets = good_packets;
        got.bad_packets = bad_packets;
        tracker.compare_result(got);
        results_seen++;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_word(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.absorb_word(op, b);
    words_sent++;
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_word(sfp_pkg::OP_BYTE, frame_bytes[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_packet();
    int         pick;
    int         plen;
    logic [7:0] ptype;
    logic [7:0] pb;
    pick = $urandom_range(99);
    frame_bytes = {};
    if (pick < 72) begin
      case ($urandom_range(2))
        0: ptype = sfp_pkg::TYPE_POS;
        1: ptype = sfp_pkg::TYPE_DIR;
        default: ptype = sfp_pkg::TYPE_CIRCLE;
      endcase
      if (ptype == sfp_pkg::TYPE_POS) plen = $urandom_range(4, 2);
      else if (ptype == sfp_pkg::TYPE_DIR) plen = $urandom_range(2, 1);
      else plen = $urandom_range(5, 4);
      // some packets too short or long enough to fill the buffer
      if ($urandom_range(9) == 0) plen = $urandom_range(6);
      frame_bytes.push_back(sfp_pkg::HDR_BYTE);
      if ($urandom_range(9) == 0) frame_bytes.push_back(sfp_pkg::HDR_BYTE);
      frame_bytes.push_back(ptype);
      repeat (plen) begin
        pb = 8'($urandom_range(254));
        if ($urandom_range(19) == 0) pb = sfp_pkg::HDR_BYTE;
        frame_bytes.push_back(pb);
      end
      frame_bytes.push_back(sfp_pkg::END_BYTE);
      send_frame_bytes();
    end else if (pick < 80) begin
      frame_bytes.push_back(sfp_pkg::HDR_BYTE);
      frame_bytes.push_back(8'($urandom_range(255)));
      send_frame_bytes();
    end else if (pick < 88) begin
      // packet cut short by a restart
      frame_bytes.push_back(sfp_pkg::HDR_BYTE);
      frame_bytes.push_back(8'($urandom_range(8'hB5, 8'hB3)));
      repeat ($urandom_range(4)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame_bytes();
      send_word(sfp_pkg::OP_RESTART, 8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(4, 1)) frame_bytes.push_back(8'($urandom_range(255)));
      send_frame_bytes();
      if ($urandom_range(3) == 0) send_word(sfp_pkg::OP_RESTART, 8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) send_random_packet();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(sfp_pkg::OP_RESTART, 8'h5A);
    frame_bytes = '{sfp_pkg::HDR_BYTE, sfp_pkg::TYPE_POS, 8'h12, 8'h34,
                    sfp_pkg::END_BYTE};
    send_frame_bytes();
    frame_bytes = '{sfp_pkg::HDR_BYTE, sfp_pkg::HDR_BYTE, sfp_pkg::TYPE_DIR, 8'h52,
                    sfp_pkg::END_BYTE};
    send_frame_bytes();
    frame_bytes = '{sfp_pkg::HDR_BYTE, 8'h00};
    send_frame_bytes();
    frame_bytes = '{sfp_pkg::HDR_BYTE, sfp_pkg::TYPE_CIRCLE, 8'h80, 8'h00, 8'h7F, 8'hFE,
                    sfp_pkg::END_BYTE};
    send_frame_bytes();
    frame_bytes = '{sfp_pkg::HDR_BYTE, sfp_pkg::TYPE_CIRCLE, sfp_pkg::HDR_BYTE,
                    sfp_pkg::END_BYTE};
    send_frame_bytes();
    // end marker lands on the last free slot: decode plus overflow
    frame_bytes = '{sfp_pkg::HDR_BYTE, sfp_pkg::TYPE_POS, 8'h01, 8'h02, 8'h7F, 8'hFE,
                    8'h03, sfp_pkg::END_BYTE};
    send_frame_bytes();
    drain();

    send_idle_pct = 24;
    recv_idle_pct = 62;
    run_random(350);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 24;
    run_random(350);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles <= LONG_HOLD;
    run_random(350);
    drain();

    repeat (6) @(posedge clk);
    $display("checked %0d reports from %0d words: %0d packets decoded, %0d errors counted",
             results_seen, words_sent, tracker.good_cnt, tracker.bad_cnt);
    $display("ran three idle mixes, a long output hold-off and drains between phases");
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
